// ===== src/cse_pkg.sv =====
// cse_pkg: types, character constants and byte classification helpers
// for the C string escaper. No dependencies.
`default_nettype none

package cse_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_cnt;

    localparam int    C_MAX_OUT   = 6;
    localparam int    C_PRE_MAX   = 4;
    localparam int    C_SUF_MAX   = 2;

    localparam t_byte C_BACKSLASH = 8'h5C;
    localparam t_byte C_QUOTE     = 8'h22;
    localparam t_byte C_ZERO      = 8'h30;
    localparam t_byte C_NINE      = 8'h39;
    localparam t_byte C_SPACE     = 8'h20;
    localparam t_byte C_TILDE     = 8'h7E;

    localparam t_byte C_BEL       = 8'h07;
    localparam t_byte C_BS        = 8'h08;
    localparam t_byte C_TAB       = 8'h09;
    localparam t_byte C_LF        = 8'h0A;
    localparam t_byte C_VT        = 8'h0B;
    localparam t_byte C_FF        = 8'h0C;
    localparam t_byte C_CR        = 8'h0D;

    localparam t_byte C_LTR_A     = 8'h61;
    localparam t_byte C_LTR_B     = 8'h62;
    localparam t_byte C_LTR_T     = 8'h74;
    localparam t_byte C_LTR_N     = 8'h6E;
    localparam t_byte C_LTR_V     = 8'h76;
    localparam t_byte C_LTR_F     = 8'h66;
    localparam t_byte C_LTR_R     = 8'h72;

    function automatic logic is_plain(input t_byte b);
        return (b >= C_SPACE) && (b <= C_TILDE) && (b != C_QUOTE) && (b != C_BACKSLASH);
    endfunction

    function automatic logic is_digit(input t_byte b);
        return (b >= C_ZERO) && (b <= C_NINE);
    endfunction

    // escape letter for a two-byte escape, zero when there is none
    function automatic t_byte simple_esc(input t_byte b);
        t_byte e;
        unique case (b)
            C_BEL:       e = C_LTR_A;
            C_BS:        e = C_LTR_B;
            C_TAB:       e = C_LTR_T;
            C_LF:        e = C_LTR_N;
            C_VT:        e = C_LTR_V;
            C_FF:        e = C_LTR_F;
            C_CR:        e = C_LTR_R;
            C_QUOTE:     e = C_QUOTE;
            C_BACKSLASH: e = C_BACKSLASH;
            default:     e = 8'h00;
        endcase
        return e;
    endfunction

    function automatic logic is_held(input t_byte b);
        return !is_plain(b) && (simple_esc(b) == 8'h00);
    endfunction

    function automatic t_byte oct_digit(input logic [2:0] d);
        return C_ZERO + {5'b00000, d};
    endfunction

endpackage

`default_nettype wire

// ===== src/c_string_escaper.sv =====
// c_string_escaper: top level, raw bytes in, C string literal text out.
// Depends on cse_pkg for types, character constants and classifiers.
//
// Input stream: tdata = raw byte, tuser = mode (0 data, 1 flush the held
// byte). Output stream: tdata = one text byte, tlast marks the final byte
// produced by one input word.
// Each accepted word is expanded and registered into a result buffer of up
// to six bytes, which drains one byte per cycle while the receiver is ready;
// the first output byte appears in the cycle after acceptance. A word that
// expands to a single byte lets the next word in on the same edge the byte
// leaves, so plain text runs at one word per cycle while the receiver is
// ready; a longer expansion holds the buffer until its last byte leaves the
// single output byte lane. Control bytes without a short escape are held one
// word to look at the next byte and yield no output on their own word.
// Reset clears the buffer and the held-byte flag. When the receiver stalls,
// the current byte holds and input is refused once the buffer cannot drain.
`default_nettype none

module c_string_escaper (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire cse_pkg::t_byte i_s_tdata,   // [7:0] data_byte
    input  wire logic           i_s_tuser,   // [0] mode
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output cse_pkg::t_byte      o_m_tdata,   // [7:0] out_byte
    output logic                o_m_tlast    // last_of_run
);

    import cse_pkg::*;

    t_byte r_buf [C_MAX_OUT];
    t_cnt  r_rem;
    logic  r_pend_valid;
    t_byte r_pend_byte;

    t_byte n_buf [C_MAX_OUT];
    t_cnt  n_len;

    logic  w_accept;
    logic  w_take;

    assign o_m_tvalid = (r_rem != 3'd0);
    assign o_m_tdata  = r_buf[0];
    assign o_m_tlast  = (r_rem == 3'd1);
    assign w_take     = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_rem == 3'd0) || ((r_rem == 3'd1) && i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // expansion: prefix encodes the held byte, suffix handles the new one
    always_comb begin
        t_byte pre [C_PRE_MAX];
        t_byte suf [C_SUF_MAX];
        t_cnt  pre_len;
        t_cnt  suf_len;
        t_cnt  sidx;
        t_byte pb;
        t_byte esc;
        pb      = r_pend_byte;
        esc     = simple_esc(i_s_tdata);
        pre[0]  = C_BACKSLASH;
        pre[1]  = oct_digit({1'b0, pb[7:6]});
        pre[2]  = oct_digit(pb[5:3]);
        pre[3]  = oct_digit(pb[2:0]);
        pre_len = 3'd0;
        suf[0]  = i_s_tdata;
        suf[1]  = esc;
        suf_len = 3'd0;
        if (r_pend_valid) begin
            if (!i_s_tuser && is_digit(i_s_tdata)) begin
                pre_len = 3'd4;
            end else if (pb[7:3] == 5'd0) begin
                pre[1]  = oct_digit(pb[2:0]);
                pre_len = 3'd2;
            end else if (pb[7:6] == 2'd0) begin
                pre[1]  = oct_digit(pb[5:3]);
                pre[2]  = oct_digit(pb[2:0]);
                pre_len = 3'd3;
            end else begin
                pre_len = 3'd4;
            end
        end
        if (!i_s_tuser) begin
            if (is_plain(i_s_tdata)) begin
                suf_len = 3'd1;
            end else if (esc != 8'h00) begin
                suf[0]  = C_BACKSLASH;
                suf_len = 3'd2;
            end
        end
        for (int k = 0; k < C_MAX_OUT; k++) begin
            sidx = 3'(k) - pre_len;
            if (3'(k) < pre_len) begin
                n_buf[k] = pre[2'(k)];
            end else if (sidx < 3'(C_SUF_MAX)) begin
                n_buf[k] = suf[sidx[0]];
            end else begin
                n_buf[k] = 8'h00;
            end
        end
        n_len = pre_len + suf_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem        <= 3'd0;
            r_pend_valid <= 1'b0;
        end else if (w_accept) begin
            r_rem        <= n_len;
            r_pend_valid <= !i_s_tuser && is_held(i_s_tdata);
        end else if (w_take) begin
            r_rem        <= r_rem - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_buf <= n_buf;
            if (!i_s_tuser && is_held(i_s_tdata)) begin
                r_pend_byte <= i_s_tdata;
            end
        end else if (w_take) begin
            for (int k = 0; k < C_MAX_OUT - 1; k++) begin
                r_buf[k] <= r_buf[k + 1];
            end
        end
    end

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= 3'(C_MAX_OUT))
        else $error("result count exceeds buffer depth");

    a_plain_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_s_tuser && !r_pend_valid && is_plain(i_s_tdata)
        |=> o_m_tvalid && o_m_tlast && (o_m_tdata == $past(i_s_tdata)))
        else $error("plain byte not passed through alone");

    a_held_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> is_held(r_pend_byte))
        else $error("held byte has a short form");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_s_tuser |=> !r_pend_valid)
        else $error("flush left a byte held");

    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_s_tuser && !r_pend_valid |=> !o_m_tvalid)
        else $error("flush with nothing held produced output");

endmodule

`default_nettype wire
